// File: rtl/c2c_pkg.sv
// ----------------------------------------------------------------------------
// c2c_pkg: shared types and constants for the Cartesian to cylindrical block
// Register indexes, angle constants, CORDIC arctangent table and the records
// passed between the front end, queue and back end.
// ----------------------------------------------------------------------------
package c2c_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_AXIS     = 3'd0;
  localparam logic [2:0] CFG_CENTRE_X = 3'd1;
  localparam logic [2:0] CFG_CENTRE_Y = 3'd2;
  localparam logic [2:0] CFG_CENTRE_Z = 3'd3;
  localparam logic [2:0] CFG_DEAD     = 3'd4;

  // Axis codes
  localparam logic [1:0] AXIS_X   = 2'd0;
  localparam logic [1:0] AXIS_Y   = 2'd1;
  localparam logic [1:0] AXIS_Z   = 2'd2;
  localparam logic [1:0] AXIS_BAD = 2'd3;

  localparam int unsigned RadW   = 32;
  localparam int unsigned AngW   = 19;
  localparam int unsigned DeadW  = 16;
  localparam int unsigned ZW     = 32;

  // Angles in Q3.16
  localparam logic [AngW-1:0] ANG_HALF_PI       = 19'd102944;
  localparam logic [AngW-1:0] ANG_PI            = 19'd205887;
  localparam logic [AngW-1:0] ANG_THREE_HALF_PI = 19'd308831;
  localparam logic [AngW-1:0] ANG_TWO_PI        = 19'd411775;

  // CORDIC gain compensation in Q0.16
  localparam logic [16:0] GAIN_Q16 = 17'd39797;

  // Quadrant flags and item kind from the front end
  typedef struct packed {
    logic last;
    logic err;
    logic u_pos;
    logic u_neg;
    logic v_pos;
    logic v_neg;
  } cls_t;

  localparam int unsigned ClsW = 6;

  // One result record
  typedef struct packed {
    logic [RadW-1:0] radius;
    logic [AngW-1:0] angle;
    logic            eol;
    logic            err;
  } res_t;

  // Arctangent of 2^-i in Q3.28
  function automatic logic [ZW-1:0] atan_q28(input logic [4:0] idx);
    logic [ZW-1:0] val;
    case (idx)
      5'd0:    val = 32'd210828714;
      5'd1:    val = 32'd124459457;
      5'd2:    val = 32'd65760959;
      5'd3:    val = 32'd33381290;
      5'd4:    val = 32'd16755422;
      5'd5:    val = 32'd8385879;
      5'd6:    val = 32'd4193963;
      5'd7:    val = 32'd2097109;
      5'd8:    val = 32'd1048571;
      5'd9:    val = 32'd524287;
      5'd10:   val = 32'd262144;
      5'd11:   val = 32'd131072;
      5'd12:   val = 32'd65536;
      5'd13:   val = 32'd32768;
      5'd14:   val = 32'd16384;
      5'd15:   val = 32'd8192;
      5'd16:   val = 32'd4096;
      5'd17:   val = 32'd2048;
      5'd18:   val = 32'd1024;
      5'd19:   val = 32'd512;
      5'd20:   val = 32'd256;
      5'd21:   val = 32'd128;
      5'd22:   val = 32'd64;
      5'd23:   val = 32'd32;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// File: rtl/c2c_front.sv
// ----------------------------------------------------------------------------
// c2c_front: input stage
// Accepts points, forms the in-plane offsets for the selected axis, takes
// their magnitudes and classifies the quadrant against the dead band.
// ----------------------------------------------------------------------------
module c2c_front #(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [COORD_BITS-1:0]     point_x_i,
  input  logic [COORD_BITS-1:0]     point_y_i,
  input  logic [COORD_BITS-1:0]     point_z_i,
  input  logic                      last_point_i,
  input  logic [1:0]                axis_i,
  input  logic [COORD_BITS-1:0]     centre_x_i,
  input  logic [COORD_BITS-1:0]     centre_y_i,
  input  logic [COORD_BITS-1:0]     centre_z_i,
  input  logic [c2c_pkg::DeadW-1:0] dead_band_i,
  output logic                      push_o,
  input  logic                      full_i,
  output logic [COORD_BITS:0]       au_o,
  output logic [COORD_BITS:0]       av_o,
  output c2c_pkg::cls_t             cls_o
);

  localparam int unsigned OW = COORD_BITS + 1;

  logic signed [OW-1:0] u, v, dbs;
  logic [COORD_BITS-1:0] pu, pv, cu, cv;
  logic                  accept;
  logic                  valid_q, valid_d;
  logic [OW-1:0]         au_q, av_q;
  c2c_pkg::cls_t         cls_q;

  // Pick the in-plane pair for the axis
  always_comb begin
    case (axis_i)
      c2c_pkg::AXIS_X: begin
        pu = point_y_i; cu = centre_y_i; pv = point_z_i; cv = centre_z_i;
      end
      c2c_pkg::AXIS_Y: begin
        pu = point_z_i; cu = centre_z_i; pv = point_x_i; cv = centre_x_i;
      end
      default: begin
        pu = point_x_i; cu = centre_x_i; pv = point_y_i; cv = centre_y_i;
      end
    endcase
  end

  assign u   = $signed({pu[COORD_BITS-1], pu}) - $signed({cu[COORD_BITS-1], cu});
  assign v   = $signed({pv[COORD_BITS-1], pv}) - $signed({cv[COORD_BITS-1], cv});
  assign dbs = $signed({{(OW-c2c_pkg::DeadW){1'b0}}, dead_band_i});

  assign push_o     = valid_q && !full_i;
  assign in_stall_o = valid_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign valid_d    = accept || (valid_q && !push_o);

  // Hold the classified item until the queue takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      au_q        <= u[OW-1] ? OW'(-u) : OW'(u);
      av_q        <= v[OW-1] ? OW'(-v) : OW'(v);
      cls_q.last  <= last_point_i;
      cls_q.err   <= (axis_i == c2c_pkg::AXIS_BAD);
      cls_q.u_pos <= (u > dbs);
      cls_q.u_neg <= (u < -dbs);
      cls_q.v_pos <= (v > dbs);
      cls_q.v_neg <= (v < -dbs);
    end
  end

  assign au_o  = au_q;
  assign av_o  = av_q;
  assign cls_o = cls_q;

endmodule

// File: rtl/c2c_queue.sv
// ----------------------------------------------------------------------------
// c2c_queue: two-entry queue
// Decouples the input stage from the CORDIC back end.
// ----------------------------------------------------------------------------
module c2c_queue #(
  parameter int unsigned DW = 72
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = mem_q[rp_q];

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= !wp_q;
      end
      if (pop_i) begin
        rp_q <= !rp_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

endmodule

// File: rtl/c2c_back.sv
// ----------------------------------------------------------------------------
// c2c_back: CORDIC back end
// Runs the iterative vectoring pass, removes the gain, places the angle by
// quadrant, applies the seam correction and sends up to two results.
// ----------------------------------------------------------------------------
module c2c_back #(
  parameter int unsigned CORDIC_STEPS = 16,
  parameter int unsigned COORD_BITS   = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  output logic                 pop_o,
  input  logic [COORD_BITS:0]  au_i,
  input  logic [COORD_BITS:0]  av_i,
  input  c2c_pkg::cls_t        cls_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output c2c_pkg::res_t        res_o
);

  localparam int unsigned G  = 60 - COORD_BITS;
  localparam int unsigned XW = 63;
  localparam int unsigned SW = $clog2(CORDIC_STEPS);
  localparam int unsigned AW = c2c_pkg::AngW;
  localparam int unsigned RW = c2c_pkg::RadW;
  localparam int unsigned HW = XW - 1 - 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_MUL,
    ST_FIN,
    ST_SEND
  } state_e;

  state_e                state_q;
  logic [SW-1:0]         step_q;
  logic signed [XW-1:0]  x_q, y_q, xs, ys;
  logic signed [c2c_pkg::ZW-1:0] z_q, atan_v;
  c2c_pkg::cls_t         cls_q;
  logic [HW+16:0]        hi_q;
  logic [15:0]           lo_q;
  logic [AW-1:0]         a_q;
  logic [XW-2:0]         xc;
  logic [c2c_pkg::ZW-1:0] zc;
  logic [20:0]           zr;

  // List state
  logic [RW-1:0]         held_r_q;
  logic [AW-1:0]         held_a_q, before_q, first_q;
  logic [1:0]            seen_q;
  logic                  held_v_q;

  c2c_pkg::res_t         out_q, spare_q;
  logic                  out_v_q, spare_v_q;

  // Finish-stage values
  logic [XW:0]           rk, rsum;
  logic [XW:0]           rsh;
  logic [RW-1:0]         rad;
  logic [AW-1:0]         th, hfix, bef_n, tfix;
  c2c_pkg::res_t         held_res, new_res, err_res;

  assign pop_o  = (state_q == ST_IDLE) && !empty_i;
  assign xs     = x_q >>> step_q;
  assign ys     = y_q >>> step_q;
  assign atan_v = $signed(c2c_pkg::atan_q28(5'(step_q)));

  // Gain removal operands and angle rounding
  assign xc = x_q[XW-1] ? '0 : x_q[XW-2:0];
  assign zc = z_q[c2c_pkg::ZW-1] ? '0 : z_q;
  assign zr = 21'((zc + 32'd2048) >> 12);

  // Radius rounding and saturation
  assign rk   = (XW+1)'(hi_q) + (XW+1)'(lo_q);
  assign rsum = rk + ((XW+1)'(1) << (G - 1));
  assign rsh  = rsum >> G;
  assign rad  = (|rsh[XW:RW]) ? '1 : rsh[RW-1:0];

  // Place the angle by quadrant
  always_comb begin
    if (cls_q.u_pos) begin
      if (cls_q.v_pos) th = a_q;
      else if (cls_q.v_neg) th = c2c_pkg::ANG_TWO_PI - a_q;
      else th = '0;
    end else if (cls_q.u_neg) begin
      if (cls_q.v_pos) th = c2c_pkg::ANG_PI - a_q;
      else if (cls_q.v_neg) th = c2c_pkg::ANG_PI + a_q;
      else th = c2c_pkg::ANG_PI;
    end else begin
      if (cls_q.v_pos) th = c2c_pkg::ANG_HALF_PI;
      else if (cls_q.v_neg) th = c2c_pkg::ANG_THREE_HALF_PI;
      else th = '0;
    end
  end

  // Seam correction
  always_comb begin
    hfix = held_a_q;
    if (seen_q >= 2'd2 && held_a_q == '0 && th == '0 && before_q != '0) begin
      hfix = c2c_pkg::ANG_TWO_PI;
    end
    bef_n = held_v_q ? hfix : before_q;
    tfix  = th;
    if (seen_q >= 2'd2 && th == '0 && first_q == '0 && bef_n != '0) begin
      tfix = c2c_pkg::ANG_TWO_PI;
    end
    held_res = '{radius: held_r_q, angle: held_a_q, eol: 1'b0, err: 1'b0};
    if (!cls_q.err) begin
      held_res.angle = hfix;
    end
    new_res = '{radius: rad, angle: tfix, eol: 1'b1, err: 1'b0};
    err_res = '{radius: '0, angle: '0, eol: cls_q.last, err: 1'b1};
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= '0;
      out_v_q   <= 1'b0;
      spare_v_q <= 1'b0;
      out_q     <= '0;
      spare_q   <= '0;
      held_v_q  <= 1'b0;
      seen_q    <= 2'd0;
      held_r_q  <= '0;
      held_a_q  <= '0;
      before_q  <= '0;
      first_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (!empty_i) begin
            step_q  <= '0;
            state_q <= cls_i.err ? ST_FIN : ST_RUN;
          end
        end
        ST_RUN: begin
          if (step_q == SW'(CORDIC_STEPS - 1)) begin
            state_q <= ST_MUL;
          end
          step_q <= step_q + SW'(1);
        end
        ST_MUL: begin
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (cls_q.err) begin
            out_v_q   <= 1'b1;
            out_q     <= held_v_q ? held_res : err_res;
            spare_q   <= err_res;
            spare_v_q <= held_v_q;
            held_v_q  <= 1'b0;
            seen_q    <= 2'd0;
            state_q   <= ST_SEND;
          end else begin
            if (held_v_q) begin
              before_q <= hfix;
            end
            if (cls_q.last) begin
              out_v_q   <= 1'b1;
              out_q     <= held_v_q ? held_res : new_res;
              spare_q   <= new_res;
              spare_v_q <= held_v_q;
              held_v_q  <= 1'b0;
              seen_q    <= 2'd0;
              state_q   <= ST_SEND;
            end else begin
              if (seen_q == 2'd0) begin
                first_q <= th;
              end
              held_r_q <= rad;
              held_a_q <= th;
              held_v_q <= 1'b1;
              if (seen_q != 2'd2) begin
                seen_q <= seen_q + 2'd1;
              end
              if (held_v_q) begin
                out_v_q <= 1'b1;
                out_q   <= held_res;
                state_q <= ST_SEND;
              end else begin
                state_q <= ST_IDLE;
              end
            end
          end
        end
        ST_SEND: begin
          if (!out_stall_i) begin
            if (spare_v_q) begin
              out_q     <= spare_q;
              spare_v_q <= 1'b0;
            end else begin
              out_v_q <= 1'b0;
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // CORDIC datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          cls_q <= cls_i;
          x_q   <= $signed({{(XW-COORD_BITS-1-G){1'b0}}, au_i, {G{1'b0}}});
          y_q   <= $signed({{(XW-COORD_BITS-1-G){1'b0}}, av_i, {G{1'b0}}});
          z_q   <= '0;
        end
      end
      ST_RUN: begin
        if (y_q > 0) begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + atan_v;
        end else begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - atan_v;
        end
      end
      ST_MUL: begin
        hi_q <= xc[XW-2:16] * c2c_pkg::GAIN_Q16;
        lo_q <= 16'((32'(xc[15:0]) * 32'(c2c_pkg::GAIN_Q16)) >> 16);
        a_q  <= (zr > 21'(c2c_pkg::ANG_HALF_PI)) ? c2c_pkg::ANG_HALF_PI : zr[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_v_q;
  assign res_o       = out_q;

endmodule

// File: rtl/cartesian_to_cylindrical.sv
// ----------------------------------------------------------------------------
// cartesian_to_cylindrical: streaming Cartesian to cylindrical conversion
// Turns Q15.16 mesh points into radius and angle about a configured axis,
// with results one point behind for the seam correction.
// ----------------------------------------------------------------------------
//   channel | handshake                | payload
//   --------+--------------------------+-------------------------------------
//   input   | in_valid_i / in_stall_o  | point_x/y/z_i, last_point_i
//   output  | out_valid_o / out_stall_i| radius_o, angle_o, end_of_list_o,
//           |                          | axis_error_o
//   config  | cfg_we_i                 | cfg_idx_i, cfg_wdata_i
//
// In the back end a point runs one CORDIC iteration per cycle, then the gain
// multiply and finish, and then sends its results, which out_stall_i can
// hold; a point with a bad axis skips the iterations and the gain multiply.
// A two-entry queue lets the input side keep accepting while the back end
// works or the output is stalled. Reset clears all list state and restores
// axis Z with a zero centre and dead band.
// ----------------------------------------------------------------------------
module cartesian_to_cylindrical #(
  parameter int unsigned CORDIC_STEPS = 16,
  parameter int unsigned COORD_BITS   = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [2:0]                 cfg_idx_i,
  input  logic [COORD_BITS-1:0]      cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [COORD_BITS-1:0]      point_x_i,
  input  logic [COORD_BITS-1:0]      point_y_i,
  input  logic [COORD_BITS-1:0]      point_z_i,
  input  logic                       last_point_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [c2c_pkg::RadW-1:0]   radius_o,
  output logic [c2c_pkg::AngW-1:0]   angle_o,
  output logic                       end_of_list_o,
  output logic                       axis_error_o
);

  localparam int unsigned OW = COORD_BITS + 1;
  localparam int unsigned DW = 2 * OW + c2c_pkg::ClsW;

  logic [1:0]                  axis_q;
  logic [COORD_BITS-1:0]       cx_q, cy_q, cz_q;
  logic [c2c_pkg::DeadW-1:0]   db_q;

  logic                        push, full, pop, empty;
  logic [OW-1:0]               f_au, f_av;
  c2c_pkg::cls_t               f_cls, q_cls;
  logic [DW-1:0]               q_rdata;
  c2c_pkg::res_t               res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q <= c2c_pkg::AXIS_Z;
      cx_q   <= '0;
      cy_q   <= '0;
      cz_q   <= '0;
      db_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        c2c_pkg::CFG_AXIS:     axis_q <= cfg_wdata_i[1:0];
        c2c_pkg::CFG_CENTRE_X: cx_q   <= cfg_wdata_i;
        c2c_pkg::CFG_CENTRE_Y: cy_q   <= cfg_wdata_i;
        c2c_pkg::CFG_CENTRE_Z: cz_q   <= cfg_wdata_i;
        c2c_pkg::CFG_DEAD:     db_q   <= cfg_wdata_i[c2c_pkg::DeadW-1:0];
        default: begin
        end
      endcase
    end
  end

  c2c_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .point_z_i    (point_z_i),
    .last_point_i (last_point_i),
    .axis_i       (axis_q),
    .centre_x_i   (cx_q),
    .centre_y_i   (cy_q),
    .centre_z_i   (cz_q),
    .dead_band_i  (db_q),
    .push_o       (push),
    .full_i       (full),
    .au_o         (f_au),
    .av_o         (f_av),
    .cls_o        (f_cls)
  );

  c2c_queue #(
    .DW (DW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({f_au, f_av, f_cls}),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (q_rdata)
  );

  assign q_cls = q_rdata[c2c_pkg::ClsW-1:0];

  c2c_back #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .COORD_BITS   (COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .pop_o       (pop),
    .au_i        (q_rdata[DW-1 -: OW]),
    .av_i        (q_rdata[c2c_pkg::ClsW +: OW]),
    .cls_i       (q_cls),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign radius_o      = res.radius;
  assign angle_o       = res.angle;
  assign end_of_list_o = res.eol;
  assign axis_error_o  = res.err;

endmodule
